### src/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 CTR package
// Shared types, the S-box and round helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds  = 10;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_IV_HIGH  = 2'd2,
    REG_IV_LOW   = 2'd3
  } cfg_reg_t;

  // one classified item handed from the front to the cipher pipeline
  typedef struct packed {
    logic [127:0] ctr;
    logic [127:0] key;
    logic [127:0] data;
    logic [15:0]  mask;
    logic [4:0]   count;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block, byte 0 most significant
  function automatic logic [7:0] byte_of(input logic [127:0] v, input int unsigned i);
    return v[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    for (int j = 0; j < 4; j++) w[j] = k[127 - 32*j -: 32];
    t = {sbox(w[3][23:16]) ^ rc, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    return {w[0], w[1], w[2], w[3]};
  endfunction

  function automatic logic [127:0] cipher_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int q = 0; q < 4; q++)
        t[4*c + q] = sbox(byte_of(s, 4*((c + q) % 4) + q));
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
    return r;
  endfunction

endpackage

### src/aes128_ctr_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 CTR block cipher
// Counter-mode encryption of 128-bit blocks with per-block byte count.
// ----------------------------------------------------------------------------
// One item per clock is accepted and one result per clock delivered while the
// output is not stalled. Items pass through the job queue, then the
// 11-stage round pipeline (initial key add plus ten rounds, key expansion
// computed alongside in each stage). The front end assigns the counter at
// acceptance, so restart and counter increment never stall the stream. A full
// output stage with out_ready low stalls the whole pipe; the two-entry queue
// keeps the input side accepting until it fills. Config writes are always
// taken; key changes apply to items accepted afterwards.
module aes128_ctr_block_cipher
  import aes_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_restart,
  input  logic [63:0]  in_data_high,
  input  logic [63:0]  in_data_low,
  input  logic [4:0]   in_valid_bytes,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  out_high,
  output logic [63:0]  out_low,
  output logic [4:0]   out_valid_bytes
);

  logic fj_valid, fj_ready, qj_valid, qj_ready;
  job_t fj, qj;

  aes_front u_front (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_restart, .in_data_high, .in_data_low, .in_valid_bytes,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  aes_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj)
  );

  aes_core u_core (
    .clk, .rst_n, .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
    .out_valid, .out_ready, .out_high, .out_low, .out_valid_bytes
  );

`ifndef SYNTH
  // a stalled result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("result changed while stalled");
  // queue never accepts when full
  a_q_full: assert property (@(posedge clk) disable iff (!rst_n)
    !fj_ready |-> !in_ready)
    else $error("input taken while queue full");
  // pipe advances whenever the output is free
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> qj_ready)
    else $error("pipe stalled with empty output");
`endif

endmodule

### src/aes_front.sv
// ----------------------------------------------------------------------------
// AES CTR front end
// Holds registers and counter, classifies each item into a cipher job.
// ----------------------------------------------------------------------------
module aes_front
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_restart,
  input  logic [63:0]  in_data_high,
  input  logic [63:0]  in_data_low,
  input  logic [4:0]   in_valid_bytes,
  output logic         job_valid,
  input  logic         job_ready,
  output job_t         job
);

  logic [63:0]  key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic [127:0] ctr_r, ctr_nxt, ctr_use;
  logic [15:0]  mask;

  assign cfg_ready = 1'b1;
  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign ctr_use   = in_restart ? {iv_high_r, iv_low_r} : ctr_r;
  assign ctr_nxt   = ctr_use + 128'd1;

  always_comb begin
    for (int i = 0; i < 16; i++) mask[15 - i] = (5'(i) < in_valid_bytes);
  end

  assign job = '{ctr: ctr_use, key: {key_high_r, key_low_r},
                 data: {in_data_high, in_data_low}, mask: mask, count: in_valid_bytes};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0; key_low_r <= '0; iv_high_r <= '0; iv_low_r <= '0;
      ctr_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_KEY_HIGH: key_high_r <= cfg_data;
          REG_KEY_LOW:  key_low_r  <= cfg_data;
          REG_IV_HIGH:  iv_high_r  <= cfg_data;
          REG_IV_LOW:   iv_low_r   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) ctr_r <= ctr_nxt;
    end
  end

endmodule

### src/aes_queue.sv
// ----------------------------------------------------------------------------
// AES job queue
// Small FIFO between the front end and the cipher pipeline.
// ----------------------------------------------------------------------------
module aes_queue
  import aes_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t          mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

### src/aes_core.sv
// ----------------------------------------------------------------------------
// AES-128 cipher pipeline
// Initial key add, then one round and one key expansion step per stage, then keystream XOR.
// ----------------------------------------------------------------------------
module aes_core
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         job_valid,
  output logic         job_ready,
  input  job_t         job,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  out_high,
  output logic [63:0]  out_low,
  output logic [4:0]   out_valid_bytes
);

  localparam int unsigned NS = NumRounds + 1;

  logic         v_r   [NS];
  logic [127:0] st_r  [NS];
  logic [127:0] key_r [NS];
  logic [127:0] dat_r [NS];
  logic [15:0]  msk_r [NS];
  logic [4:0]   cnt_r [NS];
  logic [7:0]   rc_r  [NS];
  logic         adv;
  logic [127:0] ks;

  // whole pipe advances together; empty output slot or taken result frees it
  assign adv       = !v_r[NS-1] || out_ready;
  assign job_ready = adv;
  assign out_valid = v_r[NS-1];

  always_comb begin
    for (int i = 0; i < 16; i++)
      ks[127 - 8*i -: 8] = msk_r[NS-1][15 - i] ?
        (st_r[NS-1][127 - 8*i -: 8] ^ dat_r[NS-1][127 - 8*i -: 8]) : 8'h00;
  end
  assign out_high        = ks[127:64];
  assign out_low         = ks[63:0];
  assign out_valid_bytes = cnt_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= job_valid;
      for (int s = 1; s < NS; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]  <= job.ctr ^ job.key;
      key_r[0] <= job.key;
      dat_r[0] <= job.data;
      msk_r[0] <= job.mask;
      cnt_r[0] <= job.count;
      rc_r[0]  <= 8'h01;
      for (int s = 1; s < NS; s++) begin
        key_r[s] <= next_key(key_r[s-1], rc_r[s-1]);
        st_r[s]  <= cipher_round(st_r[s-1], s == NS - 1) ^
                    next_key(key_r[s-1], rc_r[s-1]);
        rc_r[s]  <= xtime(rc_r[s-1]);
        dat_r[s] <= dat_r[s-1];
        msk_r[s] <= msk_r[s-1];
        cnt_r[s] <= cnt_r[s-1];
      end
    end
  end

endmodule
